// File: hw/rtl/i2c_eeprom_byte_master_macros.svh
// Assertion macros shared by the RTL of the I2C EEPROM byte master.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef I2C_EEPROM_BYTE_MASTER_MACROS_SVH
`define I2C_EEPROM_BYTE_MASTER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define IEBM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define IEBM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/iebm_pkg.sv
// Types and constants of the I2C EEPROM byte master.
// Used by iebm_seq and i2c_eeprom_byte_master; depends on nothing else.
`timescale 1ns / 1ps

package iebm_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_POLL_LIMIT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS      = 2'd3;
	localparam int CFG_DATA_W = 16;

	// Reset values of the registers
	localparam logic [6:0]  DEV_ADDR_RST  = 7'h50;
	localparam logic [15:0] HALF_PER_RST  = 16'd250;
	localparam logic [11:0] POLL_LIM_RST  = 12'd2000;
	localparam logic [2:0]  MAX_ATT_RST   = 3'd3;
	localparam logic [11:0] POLL_CNT_MAX  = 12'hFFF;
	localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

	// Stream payload widths
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_TX_SETUP, PH_TX_HIGH, PH_TX_LOW,
		PH_ACK_SETUP, PH_ACK_SETTLE, PH_ACK_POLL, PH_ACK_END,
		PH_RX_SETUP, PH_RX_HIGH, PH_RX_LOW, PH_NK_SETUP, PH_NK_HIGH, PH_NK_LOW,
		PH_SP_A, PH_SP_B, PH_SP_C
	} phase_t;

	typedef enum logic [2:0] {
		STG_DEVW, STG_WORD, STG_DATA, STG_DEVR, STG_RECV
	} stage_t;

	typedef struct packed {
		logic [6:0]  device_address;
		logic [15:0] half_period_ticks;
		logic [11:0] ack_poll_limit;
		logic [2:0]  max_attempts;
	} cfg_t;

	typedef struct packed {
		logic       start_req;
		logic       mode;
		logic [7:0] word_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic       success;
		logic [7:0] read_data;
	} res_t;

endpackage

// File: hw/rtl/iebm_seq.sv
// Bus sequencer of the I2C EEPROM byte master: one step per accepted tick.
// Depends on iebm_pkg for the phase, stage, request and result types.
`timescale 1ns / 1ps

module iebm_seq #(
	parameter int TICK_W = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  iebm_pkg::cfg_t cfg,
	input  iebm_pkg::req_t req,
	output iebm_pkg::res_t res
);
	import iebm_pkg::*;

	localparam int CMP_W = (TICK_W + 1 > 17) ? TICK_W + 1 : 17;

	phase_t            phase_q, phase_n;
	stage_t            stage_q, stage_n;
	logic [TICK_W-1:0] tick_q, tick_n, tick_adv;
	logic [3:0]        bit_q, bit_n, bit_inc;
	logic [7:0]        shift_q, shift_n;
	logic [11:0]       poll_q, poll_n, poll_inc;
	logic [2:0]        att_q, att_n;
	logic              failed_q, failed_n;
	logic              lmode_q, lmode_n;
	logic [7:0]        laddr_q, laddr_n, ldata_q, ldata_n;
	logic [7:0]        last_q, last_n;
	logic              slot_end;
	logic [CMP_W-1:0]  tick_inc;
	logic [3:0]        tries, att_inc;
	logic              done, succ;

	// Slot timer: a slot ends at the half period or when the counter tops out
	always_comb begin
		tick_inc = CMP_W'(tick_q) + CMP_W'(1);
		slot_end = (tick_inc >= CMP_W'(cfg.half_period_ticks)) || (tick_q == '1);
		tick_adv = slot_end ? '0 : tick_inc[TICK_W-1:0];
		bit_inc  = bit_q + 4'd1;
		poll_inc = (poll_q < POLL_CNT_MAX) ? poll_q + 12'd1 : poll_q;
		tries    = (cfg.max_attempts == 3'd0) ? 4'd1 : {1'b0, cfg.max_attempts};
		att_inc  = {1'b0, att_q} + 4'd1;
	end

	// Next state of the sequencer
	always_comb begin
		phase_n  = phase_q;
		stage_n  = stage_q;
		tick_n   = tick_adv;
		bit_n    = bit_q;
		shift_n  = shift_q;
		poll_n   = poll_q;
		att_n    = att_q;
		failed_n = failed_q;
		lmode_n  = lmode_q;
		laddr_n  = laddr_q;
		ldata_n  = ldata_q;
		last_n   = last_q;
		done     = 1'b0;
		succ     = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				tick_n = tick_q;
				if (req.start_req) begin
					lmode_n  = req.mode;
					laddr_n  = req.word_addr;
					ldata_n  = req.write_data;
					att_n    = '0;
					stage_n  = STG_DEVW;
					failed_n = 1'b0;
					tick_n   = '0;
					bit_n    = '0;
					phase_n  = PH_ST_A;
				end
			end
			PH_ST_A: if (slot_end) phase_n = PH_ST_B;
			PH_ST_B: if (slot_end) phase_n = PH_ST_C;
			PH_ST_C: begin
				if (slot_end) begin
					shift_n = {cfg.device_address, stage_q == STG_DEVR};
					bit_n   = '0;
					phase_n = PH_TX_SETUP;
				end
			end
			PH_TX_SETUP: if (slot_end) phase_n = PH_TX_HIGH;
			PH_TX_HIGH:  if (slot_end) phase_n = PH_TX_LOW;
			PH_TX_LOW: begin
				if (slot_end) begin
					shift_n = {shift_q[6:0], 1'b0};
					if (bit_inc >= BITS_PER_BYTE) begin
						bit_n   = '0;
						phase_n = PH_ACK_SETUP;
					end else begin
						bit_n   = bit_inc;
						phase_n = PH_TX_SETUP;
					end
				end
			end
			PH_ACK_SETUP: if (slot_end) phase_n = PH_ACK_SETTLE;
			PH_ACK_SETTLE: begin
				if (slot_end) begin
					poll_n  = '0;
					phase_n = PH_ACK_POLL;
				end
			end
			PH_ACK_POLL: begin
				tick_n = '0;
				if (!req.sda_in) begin
					phase_n = PH_ACK_END;
				end else begin
					poll_n = poll_inc;
					if (poll_inc >= cfg.ack_poll_limit) begin
						failed_n = 1'b1;
						phase_n  = PH_ACK_END;
					end
				end
			end
			PH_ACK_END: begin
				// Choose the next byte, or go to stop on a missed ack or after the word address of a read
				if (slot_end) begin
					if (failed_q) begin
						phase_n = PH_SP_A;
					end else begin
						case (stage_q)
							STG_DEVW: begin
								stage_n = STG_WORD;
								shift_n = laddr_q;
								bit_n   = '0;
								phase_n = PH_TX_SETUP;
							end
							STG_WORD: begin
								if (lmode_q) begin
									phase_n = PH_SP_A;
								end else begin
									stage_n = STG_DATA;
									shift_n = ldata_q;
									bit_n   = '0;
									phase_n = PH_TX_SETUP;
								end
							end
							STG_DEVR: begin
								stage_n = STG_RECV;
								bit_n   = '0;
								shift_n = '0;
								phase_n = PH_RX_SETUP;
							end
							default: phase_n = PH_SP_A;
						endcase
					end
				end
			end
			PH_RX_SETUP: if (slot_end) phase_n = PH_RX_HIGH;
			PH_RX_HIGH: begin
				if (slot_end) begin
					shift_n = {shift_q[6:0], req.sda_in};
					phase_n = PH_RX_LOW;
				end
			end
			PH_RX_LOW: begin
				if (slot_end) begin
					if (bit_inc >= BITS_PER_BYTE) begin
						bit_n   = '0;
						last_n  = shift_q;
						phase_n = PH_NK_SETUP;
					end else begin
						bit_n   = bit_inc;
						phase_n = PH_RX_HIGH;
					end
				end
			end
			PH_NK_SETUP: if (slot_end) phase_n = PH_NK_HIGH;
			PH_NK_HIGH:  if (slot_end) phase_n = PH_NK_LOW;
			PH_NK_LOW:   if (slot_end) phase_n = PH_SP_A;
			PH_SP_A:     if (slot_end) phase_n = PH_SP_B;
			PH_SP_B:     if (slot_end) phase_n = PH_SP_C;
			PH_SP_C: begin
				// New start for the read part, retry on failure, else finish
				if (slot_end) begin
					if (!failed_q && lmode_q && stage_q == STG_WORD) begin
						stage_n = STG_DEVR;
						phase_n = PH_ST_A;
					end else if (failed_q && att_inc < tries) begin
						att_n    = att_inc[2:0];
						stage_n  = STG_DEVW;
						failed_n = 1'b0;
						tick_n   = '0;
						bit_n    = '0;
						phase_n  = PH_ST_A;
					end else begin
						phase_n = PH_IDLE;
						done    = 1'b1;
						succ    = !failed_q;
					end
				end
			end
			default: begin
				phase_n = PH_IDLE;
				tick_n  = '0;
			end
		endcase
	end

	// Bus levels and status after this tick
	always_comb begin
		res.busy_res  = (phase_n != PH_IDLE);
		res.done_res  = done;
		res.success   = succ;
		res.read_data = last_n;
		case (phase_n) inside
			PH_ST_B, PH_SP_B: begin
				res.scl_out     = 1'b1;
				res.sda_release = 1'b0;
			end
			PH_ST_C, PH_SP_A: begin
				res.scl_out     = 1'b0;
				res.sda_release = 1'b0;
			end
			PH_TX_SETUP, PH_TX_LOW: begin
				res.scl_out     = 1'b0;
				res.sda_release = shift_n[7];
			end
			PH_TX_HIGH: begin
				res.scl_out     = 1'b1;
				res.sda_release = shift_n[7];
			end
			PH_ACK_SETUP, PH_ACK_END, PH_RX_SETUP, PH_RX_LOW, PH_NK_SETUP,
			PH_NK_LOW: begin
				res.scl_out     = 1'b0;
				res.sda_release = 1'b1;
			end
			default: begin
				res.scl_out     = 1'b1;
				res.sda_release = 1'b1;
			end
		endcase
	end

	// Advance the state on every accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			stage_q  <= STG_DEVW;
			tick_q   <= '0;
			bit_q    <= '0;
			shift_q  <= '0;
			poll_q   <= '0;
			att_q    <= '0;
			failed_q <= 1'b0;
			lmode_q  <= 1'b0;
			laddr_q  <= '0;
			ldata_q  <= '0;
			last_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			stage_q  <= stage_n;
			tick_q   <= tick_n;
			bit_q    <= bit_n;
			shift_q  <= shift_n;
			poll_q   <= poll_n;
			att_q    <= att_n;
			failed_q <= failed_n;
			lmode_q  <= lmode_n;
			laddr_q  <= laddr_n;
			ldata_q  <= ldata_n;
			last_q   <= last_n;
		end
	end

endmodule

// File: hw/rtl/i2c_eeprom_byte_master.sv
// I2C EEPROM byte master, top level: stream handshakes, registers, result register.
// Depends on iebm_pkg, iebm_seq and i2c_eeprom_byte_master_macros.svh.
//
// Each transfer on the s_axis channel is one tick of the I2C bus sequencer:
// a request strobe with mode, word address and write byte, plus the sampled
// SDA level. Each accepted tick yields exactly one transfer on m_axis with the
// SCL level, the SDA drive, busy, the one-tick done pulse, success and the
// last byte read. A write runs start, device address, word address, data, stop;
// a read runs start, device address, word address, stop, then a new start, device
// address with read, one byte in, a NACK and stop. Missed acknowledges are retried
// up to max_attempts tries. A tick's result is registered and is on m_axis in the
// cycle after its acceptance. Throughput: one tick per cycle; the sequencer step
// sits between the s_axis acceptance and the single output register.
// When m_axis stalls, the result is held and s_axis_tready drops until it
// is taken; the bus sequence only moves on accepted ticks.
// Configuration writes on cfg are taken every cycle (cfg_ready is high).
// Reset clears the sequencer to idle and loads the register defaults:
// address 0x50, 250 ticks per half period, poll limit 2000, three tries.
`timescale 1ns / 1ps
`include "i2c_eeprom_byte_master_macros.svh"

module i2c_eeprom_byte_master #(
	parameter int TICK_COUNTER_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [0] start_req, [1] mode, [9:2] word_addr, [17:10] write_data, [18] sda_in
	input  logic [iebm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] scl_out, [1] sda_release, [2] busy_res, [3] done_res, [4] success,
	// [12:5] read_data
	output logic [iebm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [iebm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [iebm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import iebm_pkg::*;

	cfg_t                  cfg_q;
	req_t                  req;
	res_t                  res;
	logic                  step;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign step          = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Unpack the input transfer
	assign req.start_req  = s_axis_tdata[0];
	assign req.mode       = s_axis_tdata[1];
	assign req.word_addr  = s_axis_tdata[9:2];
	assign req.write_data = s_axis_tdata[17:10];
	assign req.sda_in     = s_axis_tdata[18];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address    <= DEV_ADDR_RST;
			cfg_q.half_period_ticks <= HALF_PER_RST;
			cfg_q.ack_poll_limit    <= POLL_LIM_RST;
			cfg_q.max_attempts      <= MAX_ATT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEVICE_ADDRESS:    cfg_q.device_address    <= cfg_data[6:0];
				REG_HALF_PERIOD_TICKS: cfg_q.half_period_ticks <= cfg_data[15:0];
				REG_ACK_POLL_LIMIT:    cfg_q.ack_poll_limit    <= cfg_data[11:0];
				REG_MAX_ATTEMPTS:      cfg_q.max_attempts      <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	iebm_seq #(
		.TICK_W (TICK_COUNTER_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg_q),
		.req    (req),
		.res    (res)
	);

	// Output register: load on each accepted tick, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= {3'b000, res.read_data, res.success, res.done_res,
				res.busy_res, res.sda_release, res.scl_out};
		end
	end

	`IEBM_ASSERT_NEXT(a_step_fills_out, step, out_valid_q, "accepted tick left no result")
	`IEBM_ASSERT_NOW(a_ready_when_empty, !out_valid_q, s_axis_tready, "input stalled while empty")
	`IEBM_ASSERT_NOW(a_done_not_busy, out_valid_q && out_data_q[3], !out_data_q[2],
		"done reported while busy")
	`IEBM_ASSERT_NOW(a_success_with_done, out_valid_q && out_data_q[4], out_data_q[3],
		"success without done")

endmodule

// File: verif/tb_i2c_eeprom_byte_master.sv
// Self-checking bench for the I2C EEPROM byte master: drives bus ticks on the input
// stream, plays a simple slave on SDA and checks every output tick against a local model.
// Depends on iebm_pkg and the i2c_eeprom_byte_master RTL.
`timescale 1ns / 1ps

module tb_i2c_eeprom_byte_master;
	import iebm_pkg::*;

	localparam int TCW = 16;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int HOLD_CYCLES = 400;

	// How the emulated slave answers the acknowledge poll
	typedef enum logic [1:0] {SLAVE_ACK, SLAVE_RAW, SLAVE_DEAF} slave_t;

	typedef struct {
		logic       start;
		logic       mode;
		logic [7:0] addr;
		logic [7:0] data;
		logic       sda;
		slave_t     slave;
	} bus_tick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	i2c_eeprom_byte_master #(.TICK_COUNTER_WIDTH(TCW)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Ticks waiting to be sent and bus levels waiting to be seen
	bus_tick_t tick_q[$];
	res_t      bus_levels_q[$];

	int errors = 0;
	int ticks_done = 0;
	int cycles = 0;
	int dones = 0;
	int acked_n = 0;
	int reads_n = 0;
	int hold_reqs = 0;

	// Model of the sequencer
	cfg_t        cfg_now;
	phase_t      ph;
	stage_t      stg;
	logic [TCW-1:0] tick;
	logic [3:0]  bit_idx;
	logic [7:0]  shift;
	logic [11:0] ack_wait;
	logic [2:0]  attempts;
	logic        lmode;
	logic [7:0]  laddr, ldata, last_rd;
	logic        failed;

	initial begin
		forever #5 clk = ~clk;
	end

	// Advance the slot timer; report the end of a slot
	function automatic bit slot_end();
		if (tick + 33'd1 >= cfg_now.half_period_ticks || tick == {TCW{1'b1}}) begin
			tick = '0;
			return 1'b1;
		end
		tick = tick + 1'b1;
		return 1'b0;
	endfunction

	function automatic void load_byte(input logic [7:0] b);
		shift = b;
		bit_idx = '0;
		ph = PH_TX_SETUP;
	endfunction

	function automatic void begin_attempt();
		stg = STG_DEVW;
		failed = 1'b0;
		tick = '0;
		bit_idx = '0;
		ph = PH_ST_A;
	endfunction

	// Choose what follows an acknowledge slot
	function automatic void after_ack();
		if (failed) begin
			ph = PH_SP_A;
		end else begin
			case (stg)
				STG_DEVW: begin
					stg = STG_WORD;
					load_byte(laddr);
				end
				STG_WORD: begin
					if (lmode) begin
						ph = PH_SP_A;
					end else begin
						stg = STG_DATA;
						load_byte(ldata);
					end
				end
				STG_DEVR: begin
					stg = STG_RECV;
					bit_idx = '0;
					shift = '0;
					ph = PH_RX_SETUP;
				end
				default: ph = PH_SP_A;
			endcase
		end
	endfunction

	// Step the model by one bus tick and return the line levels it predicts
	function automatic res_t bus_tick(input bus_tick_t t);
		res_t r;
		logic [2:0] tries;
		r = '0;
		tries = (cfg_now.max_attempts == 3'd0) ? 3'd1 : cfg_now.max_attempts;
		case (ph)
			PH_IDLE: begin
				if (t.start) begin
					lmode = t.mode;
					laddr = t.addr;
					ldata = t.data;
					attempts = '0;
					begin_attempt();
				end
			end
			PH_ST_A: if (slot_end()) ph = PH_ST_B;
			PH_ST_B: if (slot_end()) ph = PH_ST_C;
			PH_ST_C: if (slot_end()) load_byte({cfg_now.device_address, stg == STG_DEVR});
			PH_TX_SETUP: if (slot_end()) ph = PH_TX_HIGH;
			PH_TX_HIGH: if (slot_end()) ph = PH_TX_LOW;
			PH_TX_LOW: begin
				if (slot_end()) begin
					shift = {shift[6:0], 1'b0};
					bit_idx = bit_idx + 1'b1;
					if (bit_idx >= BITS_PER_BYTE) begin
						bit_idx = '0;
						ph = PH_ACK_SETUP;
					end else begin
						ph = PH_TX_SETUP;
					end
				end
			end
			PH_ACK_SETUP: if (slot_end()) ph = PH_ACK_SETTLE;
			PH_ACK_SETTLE: begin
				if (slot_end()) begin
					ack_wait = '0;
					ph = PH_ACK_POLL;
				end
			end
			PH_ACK_POLL: begin
				tick = '0;
				if (!t.sda) begin
					ph = PH_ACK_END;
				end else begin
					if (ack_wait != POLL_CNT_MAX) ack_wait = ack_wait + 1'b1;
					if (ack_wait >= cfg_now.ack_poll_limit) begin
						failed = 1'b1;
						ph = PH_ACK_END;
					end
				end
			end
			PH_ACK_END: if (slot_end()) after_ack();
			PH_RX_SETUP: if (slot_end()) ph = PH_RX_HIGH;
			PH_RX_HIGH: begin
				if (slot_end()) begin
					shift = {shift[6:0], t.sda};
					ph = PH_RX_LOW;
				end
			end
			PH_RX_LOW: begin
				if (slot_end()) begin
					bit_idx = bit_idx + 1'b1;
					if (bit_idx >= BITS_PER_BYTE) begin
						bit_idx = '0;
						last_rd = shift;
						ph = PH_NK_SETUP;
					end else begin
						ph = PH_RX_HIGH;
					end
				end
			end
			PH_NK_SETUP: if (slot_end()) ph = PH_NK_HIGH;
			PH_NK_HIGH: if (slot_end()) ph = PH_NK_LOW;
			PH_NK_LOW: if (slot_end()) ph = PH_SP_A;
			PH_SP_A: if (slot_end()) ph = PH_SP_B;
			PH_SP_B: if (slot_end()) ph = PH_SP_C;
			PH_SP_C: begin
				if (slot_end()) begin
					if (!failed && lmode && stg == STG_WORD) begin
						stg = STG_DEVR;
						ph = PH_ST_A;
					end else if (failed && int'(attempts) + 1 < int'(tries)) begin
						attempts = attempts + 1'b1;
						begin_attempt();
					end else begin
						ph = PH_IDLE;
						r.done_res = 1'b1;
						r.success = !failed;
						dones++;
						if (!failed) acked_n++;
						if (!failed && lmode) reads_n++;
					end
				end
			end
			default: begin
				ph = PH_IDLE;
				tick = '0;
			end
		endcase

		// Line levels of the phase now entered
		case (ph)
			PH_ST_B, PH_SP_B: begin
				r.scl_out = 1'b1;
				r.sda_release = 1'b0;
			end
			PH_ST_C, PH_SP_A: begin
				r.scl_out = 1'b0;
				r.sda_release = 1'b0;
			end
			PH_TX_SETUP, PH_TX_LOW: begin
				r.scl_out = 1'b0;
				r.sda_release = shift[7];
			end
			PH_TX_HIGH: begin
				r.scl_out = 1'b1;
				r.sda_release = shift[7];
			end
			PH_ACK_SETUP, PH_ACK_END, PH_RX_SETUP, PH_RX_LOW, PH_NK_SETUP, PH_NK_LOW: begin
				r.scl_out = 1'b0;
				r.sda_release = 1'b1;
			end
			default: begin
				r.scl_out = 1'b1;
				r.sda_release = 1'b1;
			end
		endcase
		r.busy_res = (ph != PH_IDLE);
		r.read_data = last_rd;
		return r;
	endfunction

	// SDA as the slave drives it, given the phase the next tick meets
	function automatic logic slave_sda(input bus_tick_t t);
		if (ph != PH_ACK_POLL) return t.sda;
		case (t.slave)
			SLAVE_ACK:  return 1'b0;
			SLAVE_DEAF: return 1'b1;
			default:    return t.sda;
		endcase
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_tick(input bus_tick_t t);
		logic [IN_DATA_W-1:0] w;
		w = '0;
		w[0] = t.start;
		w[1] = t.mode;
		w[9:2] = t.addr;
		w[17:10] = t.data;
		w[18] = t.sda;
		return w;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 2);
		if (r < 95) return $urandom_range(3, 8);
		return $urandom_range(20, 80);
	endfunction

	function automatic slave_t pick_slave();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return SLAVE_ACK;
		if (r < 85) return SLAVE_RAW;
		return SLAVE_DEAF;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// Sender: predict each accepted tick, then offer the next one
	int tx_gap = 0;
	int tx_steady = 0;
	bus_tick_t cur;
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				bus_levels_q.push_back(bus_tick(cur));
				ticks_done++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (tick_q.size() != 0) begin
					cur = tick_q.pop_front();
					cur.sda = slave_sda(cur);
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pack_tick(cur);
					if (tx_steady > 0) tx_steady--;
					else if ($urandom_range(0, 199) == 0) tx_steady = $urandom_range(40, 160);
					else if ($urandom_range(0, 2) == 0) tx_gap = gap_len();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	int rx_stall = 0;
	int rx_steady = 0;
	int hold_seen = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				rx_stall = HOLD_CYCLES;
			end
			if (rx_stall > 0) begin
				rx_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (rx_steady > 0) rx_steady--;
				else if ($urandom_range(0, 199) == 0) rx_steady = $urandom_range(40, 160);
				else if ($urandom_range(0, 3) == 0) rx_stall = gap_len();
			end
		end
	end

	// Monitor: compare each output transfer with the oldest prediction
	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (bus_levels_q.size() == 0) begin
				$error("output transfer with no prediction pending: %h", m_axis_tdata);
				errors++;
			end else begin
				want = bus_levels_q.pop_front();
				check_field("scl_out", int'(want.scl_out), int'(m_axis_tdata[0]));
				check_field("sda_release", int'(want.sda_release), int'(m_axis_tdata[1]));
				check_field("busy_res", int'(want.busy_res), int'(m_axis_tdata[2]));
				check_field("done_res", int'(want.done_res), int'(m_axis_tdata[3]));
				check_field("success", int'(want.success), int'(m_axis_tdata[4]));
				check_field("read_data", int'(want.read_data), int'(m_axis_tdata[12:5]));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// Wait until every tick is sent and every result seen
	task automatic wait_drained();
		do @(posedge clk);
		while (tick_q.size() != 0 || s_axis_tvalid || bus_levels_q.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	// Write all four registers back to back; call on a clock edge
	task automatic program_regs(input cfg_t c);
		logic [CFG_IDX_W-1:0] idx;
		logic [15:0] word;
		for (int i = 0; i < 4; i++) begin
			word = 16'($urandom);
			case (i)
				0: begin
					idx = REG_DEVICE_ADDRESS;
					word[6:0] = c.device_address;
				end
				1: begin
					idx = REG_HALF_PERIOD_TICKS;
					word = c.half_period_ticks;
				end
				2: begin
					idx = REG_ACK_POLL_LIMIT;
					word[11:0] = c.ack_poll_limit;
				end
				default: begin
					idx = REG_MAX_ATTEMPTS;
					word[2:0] = c.max_attempts;
				end
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= word;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		cfg_now = c;
	endtask

	task automatic queue_tick(input logic st, md, input logic [7:0] a, d, input slave_t s);
		bus_tick_t t;
		t.start = st;
		t.mode = md;
		t.addr = a;
		t.data = d;
		t.sda = 1'($urandom_range(0, 1));
		t.slave = s;
		tick_q.push_back(t);
	endtask

	// Follower ticks: mostly no request, now and then one that a busy block ignores
	task automatic queue_followers(input int n, input slave_t s, input int start_odds);
		for (int i = 0; i < n; i++)
			queue_tick($urandom_range(0, start_odds - 1) == 0, 1'($urandom_range(0, 1)),
				8'($urandom), 8'($urandom), s);
	endtask

	// Keep ticking in short bursts until the block is idle again
	task automatic finish_request(input slave_t s, input int limit);
		int sent;
		sent = 0;
		while (ph != PH_IDLE && sent < limit) begin
			queue_followers(32, s, 64);
			sent += 32;
			wait_drained();
		end
	endtask

	// Issue one request and keep ticking until the block is idle again
	task automatic run_request(input logic md, input logic [7:0] a, d, input slave_t s,
			input int limit);
		queue_tick(1'b1, md, a, d, s);
		queue_followers(32, s, 64);
		wait_drained();
		finish_request(s, limit);
	endtask

	initial begin : stimulus
		cfg_t c;
		int hp;
		int rand_goal;
		int phase_n;
		// Reset state of the model
		cfg_now = {DEV_ADDR_RST, HALF_PER_RST, POLL_LIM_RST, MAX_ATT_RST};
		ph = PH_IDLE;
		stg = STG_DEVW;
		tick = '0;
		bit_idx = '0;
		shift = '0;
		ack_wait = '0;
		attempts = '0;
		lmode = 1'b0;
		laddr = '0;
		ldata = '0;
		last_rd = '0;
		failed = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: the first slot runs its full length under a long receiver hold-off
		queue_tick(1'b1, 1'b0, 8'hFF, 8'h00, SLAVE_ACK);
		queue_followers(260, SLAVE_ACK, 64);
		hold_reqs++;
		wait_drained();
		// Shorten the slot mid-request; address, poll limit and tries keep their reset values
		c = cfg_now;
		c.half_period_ticks = 16'd1;
		program_regs(c);
		finish_request(SLAVE_ACK, 320);

		// Top address, shortest slots: a write and a read
		program_regs('{7'h7F, 16'd1, 12'd4, 3'd1});
		run_request(1'b0, 8'h00, 8'hFF, SLAVE_ACK, 400);
		run_request(1'b1, 8'hA5, 8'h5A, SLAVE_ACK, 400);

		// Long acknowledge poll, missed twice
		program_regs('{7'h00, 16'd1, 12'd40, 3'd2});
		run_request(1'b0, 8'h81, 8'h7E, SLAVE_DEAF, 400);

		// Most attempts, each failing at once
		program_regs('{7'h55, 16'd1, 12'd1, 3'd7});
		run_request(1'b1, 8'h18, 8'hE7, SLAVE_DEAF, 400);

		// Zero registers act as one
		program_regs('{7'h00, 16'd0, 12'd0, 3'd0});
		run_request(1'b0, 8'h42, 8'h24, SLAVE_DEAF, 200);
		run_request(1'b1, 8'hFE, 8'h01, SLAVE_RAW, 300);

		// Longest slot, then shorten it while the request is still running
		program_regs('{7'h2A, 16'd65535, 12'd3, 3'd3});
		queue_tick(1'b1, 1'b1, 8'h99, 8'h66, SLAVE_ACK);
		queue_followers(60, SLAVE_ACK, 64);
		wait_drained();
		c = cfg_now;
		c.half_period_ticks = 16'd1;
		program_regs(c);
		finish_request(SLAVE_ACK, 300);

		// Random phases: fresh registers, then request runs with random content
		rand_goal = ticks_done + 250;
		phase_n = 0;
		while (ticks_done < rand_goal) begin
			c.device_address = 7'($urandom);
			c.half_period_ticks = ($urandom_range(0, 9) < 9) ? 16'($urandom_range(1, 2)) :
				16'($urandom_range(0, 6));
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: c.ack_poll_limit = 12'($urandom_range(1, 6));
				7, 8: c.ack_poll_limit = 12'($urandom_range(0, 40));
				default: c.ack_poll_limit = 12'($urandom_range(0, 300));
			endcase
			c.max_attempts = 3'($urandom);
			program_regs(c);
			hp = (c.half_period_ticks == 16'd0) ? 1 : int'(c.half_period_ticks);
			for (int k = 0; k < 2; k++) begin
				if ($urandom_range(0, 7) == 0) begin
					// noise: about half of the ticks carry a request
					queue_followers(40, SLAVE_RAW, 2);
				end else begin
					queue_tick(1'b1, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
						pick_slave());
					queue_followers(40 * hp + 20, pick_slave(), 32);
				end
			end
			if (phase_n == 1) hold_reqs++;
			phase_n++;
			wait_drained();
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (bus_levels_q.size() != 0) begin
			$error("%0d predicted results never arrived", bus_levels_q.size());
			errors++;
		end
		$display("covered %0d bus ticks in %0d cycles over %0d random register settings",
			ticks_done, cycles, phase_n);
		$display("%0d requests finished, %0d acknowledged, %0d of them reads",
			dones, acked_n, reads_n);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
